### rtl/core/tpsd_pkg.sv
// Package for the TGA pixel stream decoder.
// Holds the configuration register indexes, the fixed field widths, the pixel size reset value and the masks.
// It depends on nothing else and is imported by the top level.
package tpsd_pkg;

  // Index of each configuration register on the write port.
  typedef enum logic [1:0] {
    REG_BYTES_PER_PIXEL  = 2'd0,
    REG_RUN_LENGTH_CODED = 2'd1,
    REG_IMAGE_WIDTH      = 2'd2,
    REG_IMAGE_HEIGHT     = 2'd3
  } cfg_reg_t;

  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned PIX_COUNT_W = 32;

  // Reset value of the pixel size register.
  localparam logic [2:0] BPP_RESET = 3'd4;

  // Masks for the 16-bit 5-5-5 pixel layout and the packet header count.
  localparam logic [7:0] MASK_HI_RED   = 8'h7c;
  localparam logic [7:0] MASK_HI_GREEN = 8'h03;
  localparam logic [7:0] MASK_LO_GREEN = 8'he0;
  localparam logic [7:0] MASK_LO_BLUE  = 8'h1f;
  localparam logic [7:0] MASK_ALPHA    = 8'h80;
  localparam logic [7:0] MASK_COUNT    = 8'h7f;

endpackage

### rtl/core/tga_pixel_stream_decoder.sv
// Top level of the TGA pixel stream decoder: uncompressed and run-length
// truecolour pixel bytes in, one decoded colour per pixel or run out.
// Depends on tpsd_pkg for register indexes, widths and masks.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+--------------------------------
//   in_     | input     | in_valid / in_ready   | in_data_byte
//   out_    | output    | out_valid / out_ready | red, green, blue, alpha,
//           |           |                       | repeat_res, image_done
//   cfg_    | input     | cfg_we                | cfg_index, cfg_wdata
//
// One byte is taken per cycle while in_ready is high. Each byte updates the stream state in the
// cycle it is accepted, and a completed pixel lands in the output register
// at the same edge, so its result is visible in the cycle after the transfer.
// The output register is the only buffer: while it holds a result that is
// not taken, in_ready is low. Reset is synchronous and active low; the
// pixel size resets to 4 bytes, awaiting_r to one, other control to zero.
module tga_pixel_stream_decoder
  import tpsd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_data_byte,

  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_red,
  output logic [7:0]            out_green,
  output logic [7:0]            out_blue,
  output logic [7:0]            out_alpha,
  output logic [7:0]            out_repeat_res,
  output logic                  out_image_done,

  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers and the registered pixel total.
  logic [2:0]             bpp_r;
  logic                   rle_r;
  logic [15:0]            width_r;
  logic [15:0]            height_r;
  logic [PIX_COUNT_W-1:0] total_r, total_nxt;

  // Stream state.
  logic                   awaiting_r, awaiting_nxt;
  logic [1:0]             pos_r, pos_nxt;
  logic [23:0]            partial_r, partial_nxt;
  logic [7:0]             left_r, left_nxt;
  logic                   run_r, run_nxt;
  logic [PIX_COUNT_W-1:0] done_cnt_r, done_cnt_nxt;

  // Output register.
  logic                   out_valid_r, out_valid_nxt;
  logic [7:0]             red_r, red_nxt;
  logic [7:0]             green_r, green_nxt;
  logic [7:0]             blue_r, blue_nxt;
  logic [7:0]             alpha_r, alpha_nxt;
  logic [7:0]             rep_r, rep_nxt;
  logic                   img_done_r, img_done_nxt;

  logic                   in_xfer;
  logic                   out_xfer;

  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid_r && out_ready;

  // The product is formed as the width or height is written, so the total
  // is current as soon as the register itself is.
  always_comb begin
    total_nxt = total_r;
    if (cfg_we) begin
      if (cfg_index == REG_IMAGE_WIDTH) begin
        total_nxt = PIX_COUNT_W'(cfg_wdata) * PIX_COUNT_W'(height_r);
      end else if (cfg_index == REG_IMAGE_HEIGHT) begin
        total_nxt = PIX_COUNT_W'(width_r) * PIX_COUNT_W'(cfg_wdata);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r    <= BPP_RESET;
      rle_r    <= 1'b0;
      width_r  <= '0;
      height_r <= '0;
      total_r  <= '0;
    end else begin
      total_r <= total_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_BYTES_PER_PIXEL:  bpp_r    <= cfg_wdata[2:0];
          REG_RUN_LENGTH_CODED: rle_r    <= cfg_wdata[0];
          REG_IMAGE_WIDTH:      width_r  <= cfg_wdata;
          REG_IMAGE_HEIGHT:     height_r <= cfg_wdata;
          default:              ;
        endcase
      end
    end
  end

  // Per-byte decode: clear check, packet header, byte gathering and pixel
  // completion, all settled within the cycle of the transfer.
  logic [PIX_COUNT_W:0]   diff;
  logic                   stale;
  logic [PIX_COUNT_W-1:0] remaining;
  logic [2:0]             nbytes;
  logic [7:0]             q0, q1, q2, q3;
  logic [7:0]             left_use;
  logic [7:0]             rep;
  logic                   last_pix;

  always_comb begin
    diff      = {1'b0, total_r} - {1'b0, done_cnt_r};
    stale     = diff[PIX_COUNT_W] || (diff[PIX_COUNT_W-1:0] == '0);
    remaining = stale ? total_r : diff[PIX_COUNT_W-1:0];

    // Out-of-range pixel sizes fold onto the nearest legal one.
    unique case (bpp_r)
      3'd0, 3'd1, 3'd2: nbytes = 3'd2;
      3'd3:             nbytes = 3'd3;
      default:          nbytes = 3'd4;
    endcase

    // Start from the state as it stands after any stale-image clear.
    awaiting_nxt = stale ? 1'b1  : awaiting_r;
    pos_nxt      = stale ? 2'd0  : pos_r;
    partial_nxt  = stale ? 24'd0 : partial_r;
    left_nxt     = stale ? 8'd0  : left_r;
    run_nxt      = stale ? 1'b0  : run_r;
    done_cnt_nxt = stale ? '0    : done_cnt_r;

    q0 = partial_nxt[7:0];
    q1 = partial_nxt[15:8];
    q2 = partial_nxt[23:16];
    q3 = 8'd0;
    unique case (nbytes)
      3'd2:    q1 = in_data_byte;
      3'd3:    q2 = in_data_byte;
      default: q3 = in_data_byte;
    endcase

    left_use = (left_nxt == 8'd0) ? 8'd1 : left_nxt;
    rep      = 8'd1;
    last_pix = 1'b0;

    out_valid_nxt = out_valid_r && !out_xfer;
    red_nxt       = red_r;
    green_nxt     = green_r;
    blue_nxt      = blue_r;
    alpha_nxt     = alpha_r;
    rep_nxt       = rep_r;
    img_done_nxt  = img_done_r;

    if (!in_xfer) begin
      awaiting_nxt = awaiting_r;
      pos_nxt      = pos_r;
      partial_nxt  = partial_r;
      left_nxt     = left_r;
      run_nxt      = run_r;
      done_cnt_nxt = done_cnt_r;
    end else if (total_r == '0) begin
      // An empty image swallows the byte; only the clear above applies.
    end else if (rle_r && awaiting_nxt) begin
      // Packet header: count of 1 to 128 and the run flag.
      left_nxt     = (in_data_byte & MASK_COUNT) + 8'd1;
      run_nxt      = in_data_byte[7];
      awaiting_nxt = 1'b0;
    end else if (({1'b0, pos_nxt} + 3'd1) < nbytes) begin
      // Gather another byte of the pixel, little-endian.
      unique case (pos_nxt)
        2'd0:    partial_nxt[7:0]   = partial_nxt[7:0]   | in_data_byte;
        2'd1:    partial_nxt[15:8]  = partial_nxt[15:8]  | in_data_byte;
        default: partial_nxt[23:16] = partial_nxt[23:16] | in_data_byte;
      endcase
      pos_nxt = pos_nxt + 2'd1;
    end else begin
      partial_nxt = 24'd0;
      pos_nxt     = 2'd0;

      // Packet bookkeeping in run-length mode.
      if (rle_r) begin
        if (run_nxt) begin
          rep      = left_use;
          left_nxt = 8'd0;
        end else begin
          left_nxt = left_use - 8'd1;
        end
        if (left_nxt == 8'd0) begin
          awaiting_nxt = 1'b1;
        end
      end

      // Clip the repeat to the pixels left in the image.
      if ((remaining[PIX_COUNT_W-1:8] == '0) && (rep >= remaining[7:0])) begin
        rep      = remaining[7:0];
        last_pix = 1'b1;
      end
      done_cnt_nxt = done_cnt_nxt + {{(PIX_COUNT_W-8){1'b0}}, rep};

      if (last_pix) begin
        awaiting_nxt = 1'b1;
        pos_nxt      = 2'd0;
        partial_nxt  = 24'd0;
        left_nxt     = 8'd0;
        run_nxt      = 1'b0;
        done_cnt_nxt = '0;
      end

      // Colour expansion.
      if (nbytes == 3'd2) begin
        red_nxt   = (q1 & MASK_HI_RED) << 1;
        green_nxt = ((q1 & MASK_HI_GREEN) << 6) | ((q0 & MASK_LO_GREEN) >> 2);
        blue_nxt  = (q0 & MASK_LO_BLUE) << 3;
        alpha_nxt = q1 & MASK_ALPHA;
      end else begin
        red_nxt   = q2;
        green_nxt = q1;
        blue_nxt  = q0;
        alpha_nxt = q3;
      end
      rep_nxt       = rep;
      img_done_nxt  = last_pix;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_r  <= 1'b1;
      pos_r       <= 2'd0;
      partial_r   <= 24'd0;
      left_r      <= 8'd0;
      run_r       <= 1'b0;
      done_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      awaiting_r  <= awaiting_nxt;
      pos_r       <= pos_nxt;
      partial_r   <= partial_nxt;
      left_r      <= left_nxt;
      run_r       <= run_nxt;
      done_cnt_r  <= done_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload carries no reset.
  always_ff @(posedge clk) begin
    red_r      <= red_nxt;
    green_r    <= green_nxt;
    blue_r     <= blue_nxt;
    alpha_r    <= alpha_nxt;
    rep_r      <= rep_nxt;
    img_done_r <= img_done_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_red        = red_r;
  assign out_green      = green_r;
  assign out_blue       = blue_r;
  assign out_alpha      = alpha_r;
  assign out_repeat_res = rep_r;
  assign out_image_done = img_done_r;

  // A flagged result always leaves the pixel count cleared behind it.
  a_done_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && img_done_r |-> done_cnt_r == '0)
    else $error("pixel count not cleared after end of image");

  // Every result covers at least one pixel.
  a_repeat_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> rep_r != 8'd0)
    else $error("result with zero repeat");

  // The input stalls only behind a result that is waiting.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid_r && !out_ready)
    else $error("input stalled without a waiting result");

endmodule
